// ----- rtl/jsmt_pkg.sv -----
package jsmt_pkg;

   // Iteration limit of the escape-time loop.
   localparam int unsigned ITERATIONS = 200;
   // Counter width: it must hold ITERATIONS itself.
   localparam int unsigned ITER_W = $clog2(ITERATIONS + 1);

   localparam int unsigned COORD_W = 16;
   localparam int unsigned CONST_W = 23;
   localparam int unsigned Z_W     = 32;
   localparam int unsigned PROD_W  = 2 * Z_W;
   localparam int unsigned FRAC_BITS = 20;

   // |z|^2 limit in Q24.40.
   localparam logic signed [PROD_W-1:0] ESCAPE_LIMIT = 64'sd1000 <<< (2 * FRAC_BITS);

   localparam logic signed [CONST_W-1:0] CONST_REAL_RESET = -23'sd838861;
   localparam logic signed [CONST_W-1:0] CONST_IMAG_RESET = 23'sd163578;

   typedef enum logic {
      CSR_CONST_REAL = 1'b0,
      CSR_CONST_IMAG = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_CROSS,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_RE_RE,
      MUL_IM_IM,
      MUL_RE_IM
   } mul_sel_type;

endpackage

// ----- rtl/jsmt_req_if.sv -----
interface jsmt_req_if
   import jsmt_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] coord_u;
   logic [COORD_W-1:0] coord_v;

   modport source (output valid, output coord_u, output coord_v, input ready);
   modport sink   (input valid, input coord_u, input coord_v, output ready);
endinterface

// ----- rtl/jsmt_rsp_if.sv -----
interface jsmt_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, output inside_res, input ready);
   modport sink   (input valid, input inside_res, output ready);
endinterface

// ----- rtl/julia_set_membership_test.sv -----
// Julia set escape-time test: one shared 32x32 multiplier under a small sequencer.
// A request beat is taken in the idle state. Each pass then runs SQ_RE, SQ_IM and CROSS;
// UPDATE follows unless z escaped or n, the number of updates, has reached ITERATIONS = 200.
// One item at a time: the next request beat is taken only back in the idle state, while
// the last result may wait. An update is three multiplier passes and one add.
// Reset (synchronous, active high) empties the block and restores the default constant c.
module julia_set_membership_test
   import jsmt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   jsmt_req_if.sink            req_bus,
   jsmt_rsp_if.source          rsp_bus,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CONST_W-1:0]  csr_data
);

   // Configuration registers holding c in signed Q3.20.
   logic signed [CONST_W-1:0] const_real_ff, const_imag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         const_real_ff <= CONST_REAL_RESET;
         const_imag_ff <= CONST_IMAG_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CONST_REAL: const_real_ff <= csr_data;
            CSR_CONST_IMAG: const_imag_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Sequencer state and iteration count (number of updates already applied to z).
   state_type         state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   // Orbit value z in signed Q12.20, and the datapath registers around the multiplier.
   logic signed [Z_W-1:0]    re_ff, re_in, im_ff, im_in;
   logic signed [PROD_W-1:0] prod_ff, sq_re_ff, diff_ff;
   logic                     inside_ff, inside_in;

   logic rsp_valid_ff, rsp_valid_in, rsp_inside_ff, rsp_inside_in;

   // Combinational controls from the output decode.
   mul_sel_type mul_sel;
   logic        req_ready;

   // The shared multiplier. Its product is registered before any use.
   logic signed [Z_W-1:0] mul_a, mul_b;

   always_comb begin
      unique case (mul_sel)
         MUL_RE_RE: begin mul_a = re_ff; mul_b = re_ff; end
         MUL_IM_IM: begin mul_a = im_ff; mul_b = im_ff; end
         MUL_RE_IM: begin mul_a = re_ff; mul_b = im_ff; end
         default:   begin mul_a = re_ff; mul_b = im_ff; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // In the cross state prod_ff holds im*im and sq_re_ff holds re*re. The escape test applies
   // only once z has been updated at least once; the start point is never tested.
   logic signed [PROD_W-1:0] mag_sq;
   logic                     escaped;
   logic                     finish;

   assign mag_sq  = sq_re_ff + prod_ff;
   assign escaped = (iter_ff != '0) && (mag_sq > ESCAPE_LIMIT);
   assign finish  = escaped || (iter_ff == ITER_W'(ITERATIONS));

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_bus.valid) state_in = ST_SQ_RE;
         ST_SQ_RE:  state_in = ST_SQ_IM;
         ST_SQ_IM:  state_in = ST_CROSS;
         ST_CROSS:  state_in = finish ? ST_DONE : ST_UPDATE;
         ST_UPDATE: state_in = ST_SQ_RE;
         // Wait here until the response register is free.
         ST_DONE:   if (!rsp_valid_ff || rsp_bus.ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Output decode of the sequencer.
   always_comb begin
      req_ready = 1'b0;
      mul_sel   = MUL_RE_IM;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_SQ_RE: mul_sel   = MUL_RE_RE;
         ST_SQ_IM: mul_sel   = MUL_IM_IM;
         default:  mul_sel   = MUL_RE_IM;
      endcase
   end

   assign req_bus.ready = req_ready;

   // Datapath next values.
   always_comb begin
      re_in     = re_ff;
      im_in     = im_ff;
      iter_in   = iter_ff;
      inside_in = inside_ff;
      if (state_ff == ST_IDLE) begin
         // 2*(u - 0.5) in Q12.20: flip the MSB to subtract one half, then scale by 32.
         re_in   = {{(Z_W-COORD_W-5){~req_bus.coord_u[COORD_W-1]}}, ~req_bus.coord_u[COORD_W-1],
                    req_bus.coord_u[COORD_W-2:0], 5'b0};
         im_in   = {{(Z_W-COORD_W-5){~req_bus.coord_v[COORD_W-1]}}, ~req_bus.coord_v[COORD_W-1],
                    req_bus.coord_v[COORD_W-2:0], 5'b0};
         iter_in = '0;
      end else if (state_ff == ST_CROSS) begin
         inside_in = !escaped;
      end else if (state_ff == ST_UPDATE) begin
         // Arithmetic right shifts give the floor; doubling the cross term is one less shift.
         re_in   = diff_ff[FRAC_BITS+Z_W-1:FRAC_BITS]
                   + {{(Z_W-CONST_W){const_real_ff[CONST_W-1]}}, const_real_ff};
         im_in   = prod_ff[FRAC_BITS+Z_W-2:FRAC_BITS-1]
                   + {{(Z_W-CONST_W){const_imag_ff[CONST_W-1]}}, const_imag_ff};
         iter_in = iter_ff + ITER_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      re_ff     <= re_in;
      im_ff     <= im_in;
      inside_ff <= inside_in;
      if (state_ff == ST_SQ_IM) begin
         sq_re_ff <= prod_ff;
      end
      if (state_ff == ST_CROSS) begin
         diff_ff <= sq_re_ff - prod_ff;
      end
   end

   // Response register: a finished result may wait here while the next request beat is taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_inside_in = rsp_inside_ff;
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_bus.ready)) begin
         rsp_valid_in  = 1'b1;
         rsp_inside_in = inside_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_inside_ff <= rsp_inside_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.inside_res = rsp_inside_ff;

`ifndef NO_ASSERTIONS
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      iter_ff <= ITER_W'(ITERATIONS))
      else $error("iteration count above limit");

   a_update_below_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |-> iter_ff < ITER_W'(ITERATIONS))
      else $error("update past the iteration limit");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> state_ff == ST_SQ_RE && iter_ff == '0)
      else $error("accepted beat did not start a new orbit");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside the done state");
`endif

endmodule

// ----- tb/sv/julia_set_membership_checker.sv -----
module julia_set_membership_checker
   import jsmt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   jsmt_req_if                 req_bus,
   jsmt_rsp_if                 rsp_bus,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CONST_W-1:0]  csr_data,
   output int                  mismatches,
   output int                  verdicts_owed,
   output int                  bounded_total
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [COORD_W-1:0] u;
      logic [COORD_W-1:0] v;
      logic               bounded;
   } point_verdict_type;

   point_verdict_type verdict_queue[$];
   point_verdict_type oldest;
   point_verdict_type fresh;
   longint            c_real;
   longint            c_imag;

   // Escape-time orbit in Q12.20. An arithmetic right shift of a signed value
   // rounds toward minus infinity, which is the rounding the block uses.
   function automatic logic point_stays_bounded(input logic [COORD_W-1:0] u,
                                                input logic [COORD_W-1:0] v,
                                                input longint cr, input longint ci);
      longint re;
      longint im;
      longint next_re;
      longint next_im;
      longint u_wide;
      longint v_wide;
      u_wide = u;
      v_wide = v;
      re = (u_wide - 32768) * 32;
      im = (v_wide - 32768) * 32;
      for (int k = 0; k < ITERATIONS; k++) begin
         next_re = ((re * re - im * im) >>> FRAC_BITS) + cr;
         next_im = ((2 * (re * im)) >>> FRAC_BITS) + ci;
         re = next_re;
         im = next_im;
         if (re * re + im * im > ESCAPE_LIMIT) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         c_real = longint'(CONST_REAL_RESET);
         c_imag = longint'(CONST_IMAG_RESET);
         verdict_queue.delete();
         mismatches = 0;
         bounded_total = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_CONST_REAL) begin
               c_real = longint'($signed(csr_data));
            end else begin
               c_imag = longint'($signed(csr_data));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            fresh.u = req_bus.coord_u;
            fresh.v = req_bus.coord_v;
            fresh.bounded = point_stays_bounded(req_bus.coord_u, req_bus.coord_v,
                                                c_real, c_imag);
            if (fresh.bounded) begin
               bounded_total++;
            end
            verdict_queue.push_back(fresh);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (verdict_queue.size() == 0) begin
               $error("inside_res beat with no point outstanding: expected none, actual %0b",
                      rsp_bus.inside_res);
               mismatches++;
            end else begin
               oldest = verdict_queue.pop_front();
               if (rsp_bus.inside_res !== oldest.bounded) begin
                  $error("inside_res mismatch at u=%0d v=%0d: expected %0b, actual %0b",
                         oldest.u, oldest.v, oldest.bounded, rsp_bus.inside_res);
                  mismatches++;
               end
            end
         end
      end
      verdicts_owed <= verdict_queue.size();
   end

endmodule

// ----- tb/sv/julia_set_membership_test_tb.sv -----
module julia_set_membership_test_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import jsmt_pkg::*;

   localparam int HALF_PERIOD      = 4;
   localparam int RESET_CYCLES     = 11;
   localparam int IDLE_PCT         = 18;
   localparam int NUM_SETTINGS     = 9;
   localparam int RANDOM_PER_SET   = 171;
   // Points with these sequence numbers are sent and drained without any gaps.
   localparam int STEADY_FIRST     = 700;
   localparam int STEADY_LAST      = 899;
   // The sender stops at this point and waits for every verdict before going on.
   localparam int PAUSE_AT         = 1000;
   // The receiver refuses beats for a long stretch after this many responses.
   localparam int HOLD_AFTER_BEATS = 250;
   localparam int HOLD_CYCLES      = 3000;
   // Worst-case latency of the block, at the full iteration limit.
   localparam int SETTLE_CYCLES    = 4 * ITERATIONS + 5;
   // The slowest legal run is about 1550 points, each near the block's worst-case latency. The
   // watchdog sits several times above that.
   localparam int CYCLE_LIMIT      = 6000000;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic                csr_index;
   logic [CONST_W-1:0]  csr_data;
   logic                steady;
   int                  sent;
   int                  cycle_count;
   int                  mismatches;
   int                  verdicts_owed;
   int                  bounded_total;

   jsmt_req_if req_bus();
   jsmt_rsp_if rsp_bus();

   julia_set_membership_test u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // The checker watches both channels and the register port, predicts each verdict
   // and reports back how many verdicts are still owed and how many were wrong.
   julia_set_membership_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .mismatches    (mismatches),
      .verdicts_owed (verdicts_owed),
      .bounded_total (bounded_total)
   );

   initial clock = 1'b0;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost verdict ends the run here.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("julia_set_membership_test_tb NOT OK");
      $finish;
   end

   // Response side. It drops ready at random about 18 times in a hundred, never
   // during the steady window, and once holds ready low for a long stretch so that
   // the finished verdict backs up and the block stops taking new points while the
   // sender keeps offering one.
   initial begin : response_sink
      int beats;
      int hold_left;
      bit hold_done;
      beats = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            beats++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && beats >= HOLD_AFTER_BEATS) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
         end
         @(posedge clock);
      end
   end

   // Lowers valid and waits until every verdict that was asked for has come back.
   // The first edge lets the checker count a beat taken at the current edge.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (verdicts_owed != 0) begin
         @(posedge clock);
      end
   endtask

   // Offers one point and returns at the edge where the beat is taken. Valid stays
   // high so that the next point can follow without a gap.
   task automatic send_point(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
      if (sent == PAUSE_AT) begin
         drain();
      end
      steady = (sent >= STEADY_FIRST) && (sent <= STEADY_LAST);
      while (!steady && ($urandom_range(0, 99) < IDLE_PCT)) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.coord_u <= u;
      req_bus.coord_v <= v;
      do @(posedge clock); while (!req_bus.ready);
      sent++;
   endtask

   // Writes the selected constants on back-to-back edges. The block is idle here.
   task automatic load_constants(input logic write_real, input logic write_imag,
                                 input logic [CONST_W-1:0] c_real,
                                 input logic [CONST_W-1:0] c_imag);
      if (write_real) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_CONST_REAL;
         csr_data  <= c_real;
         @(posedge clock);
      end
      if (write_imag) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_CONST_IMAG;
         csr_data  <= c_imag;
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // The settings of c that the run walks through. The first keeps the reset value;
   // the others include zero, both extremes, a few classic connected Julia sets,
   // random values near the Mandelbrot set, fully random bit patterns, and finally
   // a write of the real part alone.
   task automatic choose_constants(input int setting, output logic write_real,
                                   output logic write_imag,
                                   output logic [CONST_W-1:0] c_real,
                                   output logic [CONST_W-1:0] c_imag);
      write_real = 1'b1;
      write_imag = 1'b1;
      c_real = '0;
      c_imag = '0;
      case (setting)
         2: begin
            c_real = 23'h400000;
            c_imag = 23'h400000;
         end
         3: begin
            c_real = 23'h3FFFFF;
            c_imag = 23'h3FFFFF;
         end
         4: begin
            c_real = -23'sd419430;
            c_imag = 23'sd629146;
         end
         5: begin
            c_real = 23'sd298844;
            c_imag = 23'sd10486;
         end
         6: begin
            c_real = CONST_W'($urandom_range(0, 2097152) - 1572864);
            c_imag = CONST_W'($urandom_range(0, 2097152) - 1048576);
         end
         7: begin
            c_real = CONST_W'($urandom_range(0, 23'h7FFFFF));
            c_imag = CONST_W'($urandom_range(0, 23'h7FFFFF));
         end
         8: begin
            c_real = CONST_REAL_RESET;
            write_imag = 1'b0;
         end
         default: begin
            // Zero: the orbit is a pure squaring, so the unit circle is the boundary.
         end
      endcase
   endtask

   // Corner points: with setting 0, the four corners, edge midpoints and the center of the
   // square, then a few points on the axes and at half radius; with setting 1 (c at zero),
   // the center and two axis points. There the center stays at zero for all iterations.
   task automatic send_corner_points(input int setting);
      logic [COORD_W-1:0] levels [3];
      levels[0] = 16'h0000;
      levels[1] = 16'h8000;
      levels[2] = 16'hFFFF;
      if (setting == 0) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               send_point(levels[i], levels[j]);
            end
         end
         send_point(16'hC000, 16'h8000);
         send_point(16'h8000, 16'h0000);
         send_point(16'h4000, 16'hC000);
      end else if (setting == 1) begin
         send_point(16'h8000, 16'h8000);
         send_point(16'hC000, 16'h8000);
         send_point(16'h8000, 16'h4000);
      end
   endtask

   // Most points are uniform over the whole field, so every bit toggles. Some are
   // drawn from the middle of the square where orbits tend to stay bounded and run
   // the full iteration count, and some hug the edges of the square.
   task automatic pick_point(output logic [COORD_W-1:0] u, output logic [COORD_W-1:0] v);
      case ($urandom_range(0, 7))
         5, 6: begin
            u = COORD_W'(16'h4000 + $urandom_range(0, 16'h7FFF));
            v = COORD_W'(16'h4000 + $urandom_range(0, 16'h7FFF));
         end
         7: begin
            u = COORD_W'($urandom_range(0, 1) ? $urandom_range(0, 63)
                                              : 16'hFFFF - $urandom_range(0, 63));
            v = COORD_W'($urandom_range(0, 16'hFFFF));
         end
         default: begin
            u = COORD_W'($urandom_range(0, 16'hFFFF));
            v = COORD_W'($urandom_range(0, 16'hFFFF));
         end
      endcase
   endtask

   initial begin : stimulus
      logic               write_real;
      logic               write_imag;
      logic [CONST_W-1:0] c_real;
      logic [CONST_W-1:0] c_imag;
      logic [COORD_W-1:0] u;
      logic [COORD_W-1:0] v;
      int                 setting;
      int                 n;

      // Every input starts at a known value before the first edge.
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.coord_u = '0;
      req_bus.coord_v = '0;
      csr_we          = 1'b0;
      csr_index       = CSR_CONST_REAL;
      csr_data        = '0;
      steady          = 1'b0;
      sent            = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Each setting of c starts from an idle block: all verdicts of the previous
      // setting are in before the registers change.
      for (setting = 0; setting < NUM_SETTINGS; setting++) begin
         if (setting != 0) begin
            drain();
            choose_constants(setting, write_real, write_imag, c_real, c_imag);
            load_constants(write_real, write_imag, c_real, c_imag);
         end
         send_corner_points(setting);
         for (n = 0; n < RANDOM_PER_SET; n++) begin
            pick_point(u, v);
            send_point(u, v);
         end
      end

      // Wait for the last verdicts, then give the block a full worst-case latency
      // to show any stray response beat.
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d points across %0d settings of c; %0d were predicted bounded.",
               sent, NUM_SETTINGS, bounded_total);
      $display("The run included a long response stall and a full drain mid-stream.");
      if (mismatches == 0 && verdicts_owed == 0) begin
         $display("julia_set_membership_test_tb OK");
      end else begin
         $display("julia_set_membership_test_tb NOT OK");
      end
      $finish;
   end

endmodule
